FILE: design/twtlc_pkg.sv
// Shared types, constants and digit helpers for the two-way traffic light controller.
package twtlc_pkg;

  // Largest duration that can be entered in an edit mode
  localparam logic [6:0] MAX_SECONDS = 7'd99;

  // Durations after reset
  localparam logic [6:0] RED_SECONDS_RST    = 7'd5;
  localparam logic [6:0] GREEN_SECONDS_RST  = 7'd3;
  localparam logic [6:0] YELLOW_SECONDS_RST = 7'd2;

  // Lamp bits
  localparam logic [5:0] LAMP_RED_A    = 6'b000001;
  localparam logic [5:0] LAMP_YELLOW_A = 6'b000010;
  localparam logic [5:0] LAMP_GREEN_A  = 6'b000100;
  localparam logic [5:0] LAMP_RED_B    = 6'b001000;
  localparam logic [5:0] LAMP_YELLOW_B = 6'b010000;
  localparam logic [5:0] LAMP_GREEN_B  = 6'b100000;
  localparam logic [5:0] LAMPS_A = LAMP_RED_A | LAMP_YELLOW_A | LAMP_GREEN_A;
  localparam logic [5:0] LAMPS_B = LAMP_RED_B | LAMP_YELLOW_B | LAMP_GREEN_B;

  // Operating modes; edit modes carry the number shown on the display
  typedef enum logic [2:0] {
    MODE_START       = 3'd0,
    MODE_RUN         = 3'd1,
    MODE_EDIT_RED    = 3'd2,
    MODE_EDIT_GREEN  = 3'd3,
    MODE_EDIT_YELLOW = 3'd4
  } mode_t;

  // Phase of one light; PH_LOAD means the next step loads a fresh phase
  typedef enum logic [1:0] {
    PH_LOAD   = 2'd0,
    PH_RED    = 2'd1,
    PH_GREEN  = 2'd2,
    PH_YELLOW = 2'd3
  } phase_t;

  // Divide by ten through a reciprocal; exact for all 7-bit values
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] tens_x10;
    tens_x10 = {3'd0, div10(v)} * 7'd10;
    return 4'(v - tens_x10);
  endfunction

  // Lamp of one light for a phase
  function automatic logic [5:0] phase_lamps(input phase_t ph, input logic light_b);
    logic [5:0] m;
    m = 6'd0;
    case (ph)
      PH_RED:    m = light_b ? LAMP_RED_B : LAMP_RED_A;
      PH_GREEN:  m = light_b ? LAMP_GREEN_B : LAMP_GREEN_A;
      PH_YELLOW: m = light_b ? LAMP_YELLOW_B : LAMP_YELLOW_A;
      default:   m = 6'd0;
    endcase
    return m;
  endfunction

  // Lamps of both lights for the colour under edit
  function automatic logic [5:0] edit_lamps(input mode_t md);
    logic [5:0] m;
    case (md)
      MODE_EDIT_RED:   m = LAMP_RED_A | LAMP_RED_B;
      MODE_EDIT_GREEN: m = LAMP_GREEN_A | LAMP_GREEN_B;
      default:         m = LAMP_YELLOW_A | LAMP_YELLOW_B;
    endcase
    return m;
  endfunction

endpackage

FILE: design/two_way_traffic_light_controller_top.sv
// Top level of the two-way traffic light controller: one poll step per item.
//
// Each input item is one poll step (timer expiries, ticks, button presses) and
// gives exactly one result item (lamps, four digits, timer loads and reloads).
// The block takes one item per clock while the input side is not stalled. An item
// taken waits in the input register; the whole step is evaluated by the logic
// between it and the result register, which holds the result. The input side
// stalls only while a result is held in the output register and a further item
// already waits in the input register.
module two_way_traffic_light_controller_top (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       timer_a_expired,
  input  logic       timer_b_expired,
  input  logic       second_tick,
  input  logic       blink_tick,
  input  logic       mode_press,
  input  logic       increment_press,
  input  logic       commit_press,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] lamps_lit,
  output logic [3:0] digit_a_tens,
  output logic [3:0] digit_a_units,
  output logic [3:0] digit_b_tens,
  output logic [3:0] digit_b_units,
  output logic       timer_a_load,
  output logic [6:0] timer_a_seconds,
  output logic       timer_b_load,
  output logic [6:0] timer_b_seconds,
  output logic       second_reload,
  output logic       blink_reload
);

  // Input register
  logic s1_valid;
  logic s1_exp_a, s1_exp_b, s1_tick, s1_blink, s1_mode, s1_inc, s1_commit;

  // Controller state
  twtlc_pkg::mode_t  run_mode, run_mode_next;
  twtlc_pkg::phase_t phase_a, phase_a_next;
  twtlc_pkg::phase_t phase_b, phase_b_next;
  logic [3:0] dig_at, dig_at_next, dig_au, dig_au_next;
  logic [3:0] dig_bt, dig_bt_next, dig_bu, dig_bu_next;
  logic [6:0] red_seconds, red_seconds_next;
  logic [6:0] green_seconds, green_seconds_next;
  logic [6:0] yellow_seconds, yellow_seconds_next;
  logic [6:0] pending_red, pending_red_next;
  logic [6:0] pending_green, pending_green_next;
  logic [6:0] pending_yellow, pending_yellow_next;
  logic       blink_phase, blink_phase_next;
  logic [5:0] lamp_register, lamp_register_next;

  // Per-step result terms
  logic       load_a, load_b, sec_used, blink_used;
  logic [6:0] secs_a, secs_b;

  logic in_accept, step;

  // Handshake: a step moves from the input register into the result register
  assign step      = s1_valid && !(out_valid && out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !step);
    end
    if (in_accept) begin
      s1_exp_a  <= timer_a_expired;
      s1_exp_b  <= timer_b_expired;
      s1_tick   <= second_tick;
      s1_blink  <= blink_tick;
      s1_mode   <= mode_press;
      s1_inc    <= increment_press;
      s1_commit <= commit_press;
    end
  end

  // One poll step
  always_comb begin
    twtlc_pkg::phase_t nxt;
    twtlc_pkg::mode_t  ec;
    twtlc_pkg::mode_t  nc;
    logic       do_edit, leave;
    logic [6:0] s, p, c, p_inc, p_show;

    run_mode_next       = run_mode;
    phase_a_next        = phase_a;
    phase_b_next        = phase_b;
    dig_at_next         = dig_at;
    dig_au_next         = dig_au;
    dig_bt_next         = dig_bt;
    dig_bu_next         = dig_bu;
    red_seconds_next    = red_seconds;
    green_seconds_next  = green_seconds;
    yellow_seconds_next = yellow_seconds;
    pending_red_next    = pending_red;
    pending_green_next  = pending_green;
    pending_yellow_next = pending_yellow;
    blink_phase_next    = blink_phase;
    lamp_register_next  = lamp_register;
    load_a     = 1'b0;
    load_b     = 1'b0;
    sec_used   = 1'b0;
    blink_used = 1'b0;
    secs_a     = 7'd0;
    secs_b     = 7'd0;
    do_edit    = 1'b0;
    leave      = 1'b0;
    ec         = twtlc_pkg::MODE_EDIT_RED;
    nc         = twtlc_pkg::MODE_EDIT_GREEN;
    nxt        = twtlc_pkg::PH_LOAD;
    s          = 7'd0;
    p          = 7'd0;
    c          = 7'd0;
    p_inc      = 7'd0;
    p_show     = 7'd0;

    case (run_mode)
      twtlc_pkg::MODE_START: begin
        run_mode_next = twtlc_pkg::MODE_RUN;
        phase_a_next  = twtlc_pkg::PH_LOAD;
      end

      twtlc_pkg::MODE_RUN: begin
        // light A
        if (phase_a == twtlc_pkg::PH_LOAD) begin
          load_a = 1'b1;
          nxt    = twtlc_pkg::PH_RED;
        end else begin
          lamp_register_next = (lamp_register_next & twtlc_pkg::LAMPS_B) |
                               twtlc_pkg::phase_lamps(phase_a, 1'b0);
          if (s1_exp_a) begin
            load_a = 1'b1;
            nxt    = (phase_a == twtlc_pkg::PH_YELLOW) ? twtlc_pkg::PH_RED :
                     twtlc_pkg::phase_t'(phase_a + 2'd1);
          end
        end
        if (load_a) begin
          case (nxt)
            twtlc_pkg::PH_RED:   s = red_seconds;
            twtlc_pkg::PH_GREEN: s = green_seconds;
            default:             s = yellow_seconds;
          endcase
          phase_a_next = nxt;
          secs_a       = s;
          dig_at_next  = twtlc_pkg::div10(s);
          dig_au_next  = twtlc_pkg::mod10(s) + 4'd1;
        end

        // light B
        if (phase_b == twtlc_pkg::PH_LOAD) begin
          load_b = 1'b1;
          nxt    = twtlc_pkg::PH_GREEN;
        end else begin
          lamp_register_next = (lamp_register_next & twtlc_pkg::LAMPS_A) |
                               twtlc_pkg::phase_lamps(phase_b, 1'b1);
          if (s1_exp_b) begin
            load_b = 1'b1;
            nxt    = (phase_b == twtlc_pkg::PH_YELLOW) ? twtlc_pkg::PH_RED :
                     twtlc_pkg::phase_t'(phase_b + 2'd1);
          end
        end
        if (load_b) begin
          case (nxt)
            twtlc_pkg::PH_RED:   s = red_seconds;
            twtlc_pkg::PH_GREEN: s = green_seconds;
            default:             s = yellow_seconds;
          endcase
          phase_b_next = nxt;
          secs_b       = s;
          dig_bt_next  = twtlc_pkg::div10(s);
          dig_bu_next  = twtlc_pkg::mod10(s) + 4'd1;
        end

        // countdown with borrow, tens clamp at zero
        if (s1_tick) begin
          sec_used = 1'b1;
          if (dig_au_next == 4'd0) begin
            dig_au_next = 4'd9;
            dig_at_next = (dig_at_next == 4'd0) ? 4'd0 : dig_at_next - 4'd1;
          end else begin
            dig_au_next = dig_au_next - 4'd1;
          end
          if (dig_bu_next == 4'd0) begin
            dig_bu_next = 4'd9;
            dig_bt_next = (dig_bt_next == 4'd0) ? 4'd0 : dig_bt_next - 4'd1;
          end else begin
            dig_bu_next = dig_bu_next - 4'd1;
          end
        end

        // mode press enters red edit and runs it once this step
        if (s1_mode) begin
          run_mode_next = twtlc_pkg::MODE_EDIT_RED;
          do_edit       = 1'b1;
          ec            = twtlc_pkg::MODE_EDIT_RED;
        end
      end

      twtlc_pkg::MODE_EDIT_RED, twtlc_pkg::MODE_EDIT_GREEN,
      twtlc_pkg::MODE_EDIT_YELLOW: begin
        do_edit = 1'b1;
        ec      = run_mode;
        leave   = s1_mode;
      end

      default: begin
        // unreachable modes hold all state
      end
    endcase

    // edit actions for colour ec
    if (do_edit) begin
      case (ec)
        twtlc_pkg::MODE_EDIT_RED: begin
          p = pending_red;
          c = red_seconds;
        end
        twtlc_pkg::MODE_EDIT_GREEN: begin
          p = pending_green;
          c = green_seconds;
        end
        default: begin
          p = pending_yellow;
          c = yellow_seconds;
        end
      endcase
      if (s1_blink) begin
        lamp_register_next = (blink_phase == 1'b0) ? twtlc_pkg::edit_lamps(ec) : 6'd0;
        blink_phase_next   = ~blink_phase;
        blink_used         = 1'b1;
      end
      if (s1_inc) begin
        p_inc = p + 7'd1;
        p     = (p_inc > twtlc_pkg::MAX_SECONDS) ? 7'd0 : p_inc;
      end
      if (s1_commit) begin
        c = p;
      end
      dig_at_next = twtlc_pkg::div10(p);
      dig_au_next = twtlc_pkg::mod10(p);
      dig_bt_next = 4'd0;
      dig_bu_next = {1'b0, ec};

      // leaving drops the uncommitted edit
      if (leave) begin
        p = c;
      end
      case (ec)
        twtlc_pkg::MODE_EDIT_RED: begin
          pending_red_next = p;
          red_seconds_next = c;
        end
        twtlc_pkg::MODE_EDIT_GREEN: begin
          pending_green_next = p;
          green_seconds_next = c;
        end
        default: begin
          pending_yellow_next = p;
          yellow_seconds_next = c;
        end
      endcase

      if (leave) begin
        if (ec == twtlc_pkg::MODE_EDIT_YELLOW) begin
          run_mode_next = twtlc_pkg::MODE_RUN;
          phase_a_next  = twtlc_pkg::PH_LOAD;
          phase_b_next  = twtlc_pkg::PH_LOAD;
        end else begin
          // next colour's pending value is untouched by this step
          nc = (ec == twtlc_pkg::MODE_EDIT_RED) ? twtlc_pkg::MODE_EDIT_GREEN :
               twtlc_pkg::MODE_EDIT_YELLOW;
          p_show        = (ec == twtlc_pkg::MODE_EDIT_RED) ? pending_green : pending_yellow;
          run_mode_next = nc;
          dig_at_next   = twtlc_pkg::div10(p_show);
          dig_au_next   = twtlc_pkg::mod10(p_show);
          dig_bt_next   = 4'd0;
          dig_bu_next   = {1'b0, nc};
        end
      end
    end
  end

  // State registers, updated once per step
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= twtlc_pkg::MODE_START;
      phase_a        <= twtlc_pkg::PH_LOAD;
      phase_b        <= twtlc_pkg::PH_LOAD;
      dig_at         <= 4'd0;
      dig_au         <= 4'd0;
      dig_bt         <= 4'd0;
      dig_bu         <= 4'd0;
      red_seconds    <= twtlc_pkg::RED_SECONDS_RST;
      green_seconds  <= twtlc_pkg::GREEN_SECONDS_RST;
      yellow_seconds <= twtlc_pkg::YELLOW_SECONDS_RST;
      pending_red    <= twtlc_pkg::RED_SECONDS_RST;
      pending_green  <= twtlc_pkg::GREEN_SECONDS_RST;
      pending_yellow <= twtlc_pkg::YELLOW_SECONDS_RST;
      blink_phase    <= 1'b0;
      lamp_register  <= 6'd0;
    end else if (step) begin
      run_mode       <= run_mode_next;
      phase_a        <= phase_a_next;
      phase_b        <= phase_b_next;
      dig_at         <= dig_at_next;
      dig_au         <= dig_au_next;
      dig_bt         <= dig_bt_next;
      dig_bu         <= dig_bu_next;
      red_seconds    <= red_seconds_next;
      green_seconds  <= green_seconds_next;
      yellow_seconds <= yellow_seconds_next;
      pending_red    <= pending_red_next;
      pending_green  <= pending_green_next;
      pending_yellow <= pending_yellow_next;
      blink_phase    <= blink_phase_next;
      lamp_register  <= lamp_register_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step || (out_valid && out_stall);
    end
    if (step) begin
      lamps_lit       <= lamp_register_next;
      digit_a_tens    <= dig_at_next;
      digit_a_units   <= dig_au_next;
      digit_b_tens    <= dig_bt_next;
      digit_b_units   <= dig_bu_next;
      timer_a_load    <= load_a;
      timer_a_seconds <= secs_a;
      timer_b_load    <= load_b;
      timer_b_seconds <= secs_b;
      second_reload   <= sec_used;
      blink_reload    <= blink_used;
    end
  end

`ifndef SYNTHESIS
  // a waiting item always reaches the result register when it is free
  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !(out_valid && out_stall)) |=> out_valid)
    else $error("step did not produce a result");

  // the input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held result");

  // a timer duration appears only with its load strobe
  a_secs_with_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !timer_a_load) |-> (timer_a_seconds == 7'd0 && (timer_b_load ||
      timer_b_seconds == 7'd0)))
    else $error("timer seconds without load");

  // pending durations never pass the wrap limit
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    (pending_red <= twtlc_pkg::MAX_SECONDS) && (pending_green <= twtlc_pkg::MAX_SECONDS) &&
    (pending_yellow <= twtlc_pkg::MAX_SECONDS))
    else $error("pending duration out of range");

  // units digits never exceed ten
  a_units_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_a_units <= 4'd10 && digit_b_units <= 4'd10))
    else $error("units digit out of range");
`endif

endmodule

FILE: tb/two_way_traffic_light_controller_checker.sv
// Checker for the two-way traffic light controller: predicts every poll step and compares results.
module two_way_traffic_light_controller_checker
  import twtlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       timer_a_expired,
  input  logic       timer_b_expired,
  input  logic       second_tick,
  input  logic       blink_tick,
  input  logic       mode_press,
  input  logic       increment_press,
  input  logic       commit_press,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [5:0] lamps_lit,
  input  logic [3:0] digit_a_tens,
  input  logic [3:0] digit_a_units,
  input  logic [3:0] digit_b_tens,
  input  logic [3:0] digit_b_units,
  input  logic       timer_a_load,
  input  logic [6:0] timer_a_seconds,
  input  logic       timer_b_load,
  input  logic [6:0] timer_b_seconds,
  input  logic       second_reload,
  input  logic       blink_reload,
  output int         fail_count,
  output int         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0] lamps;
    logic [3:0] a_tens;
    logic [3:0] a_units;
    logic [3:0] b_tens;
    logic [3:0] b_units;
    logic       load_a;
    logic [6:0] secs_a;
    logic       load_b;
    logic [6:0] secs_b;
    logic       sec_reload;
    logic       blink_reload;
  } light_outputs_t;

  light_outputs_t predicted_outputs[$];
  light_outputs_t step_out;
  light_outputs_t want;
  int             result_index;

  // Shadow controller state; durations indexed red, green, yellow
  mode_t      ctl_mode;
  phase_t     light_phase[2];
  int         digit[4];
  logic [6:0] committed_secs[3];
  logic [6:0] pending_secs[3];
  logic       blink_phase;
  logic [5:0] lamp_reg;

  task automatic reset_shadow();
    ctl_mode = MODE_START;
    light_phase[0] = PH_LOAD;
    light_phase[1] = PH_LOAD;
    for (int i = 0; i < 4; i++) digit[i] = 0;
    committed_secs[0] = RED_SECONDS_RST;
    committed_secs[1] = GREEN_SECONDS_RST;
    committed_secs[2] = YELLOW_SECONDS_RST;
    pending_secs = committed_secs;
    blink_phase = 1'b0;
    lamp_reg = '0;
  endtask

  // Show the current phase lamp, then move on to the next phase on expiry or reload
  task automatic advance_light(input bit light_b, input logic expired);
    phase_t     cur;
    phase_t     nxt;
    logic [5:0] own;
    logic [6:0] secs;
    int         lt;
    lt = int'(light_b);
    cur = light_phase[lt];
    nxt = cur;
    if (cur == PH_LOAD) begin
      nxt = light_b ? PH_GREEN : PH_RED;
    end else begin
      case (cur)
        PH_RED:   own = light_b ? LAMP_RED_B : LAMP_RED_A;
        PH_GREEN: own = light_b ? LAMP_GREEN_B : LAMP_GREEN_A;
        default:  own = light_b ? LAMP_YELLOW_B : LAMP_YELLOW_A;
      endcase
      lamp_reg = (lamp_reg & (light_b ? LAMPS_A : LAMPS_B)) | own;
      if (expired) nxt = (cur == PH_YELLOW) ? PH_RED : phase_t'(cur + 1);
    end
    if (nxt != cur) begin
      secs = committed_secs[int'(nxt) - int'(PH_RED)];
      light_phase[lt] = nxt;
      digit[2 * lt] = secs / 10;
      digit[2 * lt + 1] = secs % 10 + 1;
      if (light_b) begin
        step_out.load_b = 1'b1;
        step_out.secs_b = secs;
      end else begin
        step_out.load_a = 1'b1;
        step_out.secs_a = secs;
      end
    end
  endtask

  // One second off a display pair; borrow from tens, tens stops at zero
  task automatic count_down(input int pair);
    int t;
    int u;
    t = digit[2 * pair];
    u = digit[2 * pair + 1] - 1;
    if (u < 0) begin
      u = 9;
      t = (t > 0) ? t - 1 : 0;
    end
    digit[2 * pair] = t;
    digit[2 * pair + 1] = u;
  endtask

  task automatic edit_actions(input mode_t c, input logic blink, input logic inc,
                              input logic commit);
    int         k;
    logic [5:0] mask;
    logic [7:0] bumped;
    k = int'(c) - int'(MODE_EDIT_RED);
    if (blink) begin
      case (c)
        MODE_EDIT_RED:   mask = LAMP_RED_A | LAMP_RED_B;
        MODE_EDIT_GREEN: mask = LAMP_GREEN_A | LAMP_GREEN_B;
        default:         mask = LAMP_YELLOW_A | LAMP_YELLOW_B;
      endcase
      lamp_reg = blink_phase ? 6'd0 : mask;
      blink_phase = ~blink_phase;
      step_out.blink_reload = 1'b1;
    end
    if (inc) begin
      bumped = {1'b0, pending_secs[k]} + 8'd1;
      pending_secs[k] = (bumped > {1'b0, MAX_SECONDS}) ? 7'd0 : bumped[6:0];
    end
    if (commit) committed_secs[k] = pending_secs[k];
  endtask

  task automatic show_edit(input mode_t c);
    logic [6:0] p;
    p = pending_secs[int'(c) - int'(MODE_EDIT_RED)];
    digit[0] = p / 10;
    digit[1] = p % 10;
    digit[2] = 0;
    digit[3] = int'(c);
  endtask

  // Work out the result of one poll step and queue it
  task automatic predict_poll_step();
    mode_t c;
    step_out = '{default: '0};
    case (ctl_mode)
      MODE_START: begin
        ctl_mode = MODE_RUN;
        light_phase[0] = PH_LOAD;
      end
      MODE_RUN: begin
        advance_light(1'b0, timer_a_expired);
        advance_light(1'b1, timer_b_expired);
        if (second_tick) begin
          count_down(0);
          count_down(1);
          step_out.sec_reload = 1'b1;
        end
        if (mode_press) begin
          ctl_mode = MODE_EDIT_RED;
          edit_actions(MODE_EDIT_RED, blink_tick, increment_press, commit_press);
          show_edit(MODE_EDIT_RED);
        end
      end
      MODE_EDIT_RED, MODE_EDIT_GREEN, MODE_EDIT_YELLOW: begin
        c = ctl_mode;
        edit_actions(c, blink_tick, increment_press, commit_press);
        show_edit(c);
        if (mode_press) begin
          // uncommitted edits are dropped on leaving
          pending_secs[int'(c) - int'(MODE_EDIT_RED)] =
            committed_secs[int'(c) - int'(MODE_EDIT_RED)];
          if (c == MODE_EDIT_YELLOW) begin
            ctl_mode = MODE_RUN;
            light_phase[0] = PH_LOAD;
            light_phase[1] = PH_LOAD;
          end else begin
            ctl_mode = mode_t'(c + 1);
            show_edit(ctl_mode);
          end
        end
      end
      default: ;
    endcase
    step_out.lamps = lamp_reg;
    step_out.a_tens = 4'(digit[0]);
    step_out.a_units = 4'(digit[1]);
    step_out.b_tens = 4'(digit[2]);
    step_out.b_units = 4'(digit[3]);
    predicted_outputs.push_back(step_out);
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 20) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_index, name, got, exp_val));
  endtask

  // Results first, then the new item; latency keeps them apart anyway
  always @(posedge clk) begin
    if (rst) begin
      reset_shadow();
      predicted_outputs.delete();
      result_index = 0;
      pending_results <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no step outstanding",
                                    result_index));
        end else begin
          want = predicted_outputs.pop_front();
          check_field("lamps_lit", lamps_lit, want.lamps);
          check_field("digit_a_tens", digit_a_tens, want.a_tens);
          check_field("digit_a_units", digit_a_units, want.a_units);
          check_field("digit_b_tens", digit_b_tens, want.b_tens);
          check_field("digit_b_units", digit_b_units, want.b_units);
          check_field("timer_a_load", timer_a_load, want.load_a);
          check_field("timer_a_seconds", timer_a_seconds, want.secs_a);
          check_field("timer_b_load", timer_b_load, want.load_b);
          check_field("timer_b_seconds", timer_b_seconds, want.secs_b);
          check_field("second_reload", second_reload, want.sec_reload);
          check_field("blink_reload", blink_reload, want.blink_reload);
        end
        result_index++;
      end
      if (in_valid && !in_stall) predict_poll_step();
      pending_results <= predicted_outputs.size();
    end
  end

endmodule

FILE: tb/tb_two_way_traffic_light_controller_top.sv
// Testbench top for the two-way traffic light controller: clock, reset, stimulus and verdict.
module tb_two_way_traffic_light_controller_top;
  import twtlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_STEPS = 1200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;

  // One poll step as the sender builds it
  typedef struct packed {
    logic commit;
    logic increment;
    logic mode;
    logic blink;
    logic tick;
    logic expired_b;
    logic expired_a;
  } poll_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       timer_a_expired = 1'b0;
  logic       timer_b_expired = 1'b0;
  logic       second_tick = 1'b0;
  logic       blink_tick = 1'b0;
  logic       mode_press = 1'b0;
  logic       increment_press = 1'b0;
  logic       commit_press = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] lamps_lit;
  logic [3:0] digit_a_tens;
  logic [3:0] digit_a_units;
  logic [3:0] digit_b_tens;
  logic [3:0] digit_b_units;
  logic       timer_a_load;
  logic [6:0] timer_a_seconds;
  logic       timer_b_load;
  logic [6:0] timer_b_seconds;
  logic       second_reload;
  logic       blink_reload;
  int         fail_count;
  int         pending_results;

  // Idling knobs for the sender and the receiver, and the mode the sender tracks
  bit    tx_quiet = 1'b0;
  bit    rx_quiet = 1'b0;
  bit    rx_hold_req = 1'b0;
  mode_t sent_mode = MODE_START;

  // Directed steps, bits {commit, inc, mode, blink, tick, expired_b, expired_a}
  logic [6:0] directed_steps[26] = '{
    7'b1111111,  // start step: everything dropped
    7'b0000000,  // both lights load
    7'b0000000,  // red A, green B lit
    7'b0000100,  // countdown
    7'b1101000,  // edit buttons and blink ignored while running
    7'b0000101,  // A expires with a tick
    7'b0000110,  // B expires with a tick
    7'b0000011,  // both expire
    7'b0011000,  // enter red edit with a blink
    7'b0101000,  // raise red, blink off
    7'b0100000,
    7'b0101000,
    7'b1100000,  // red reaches nine and is committed
    7'b0110000,  // leave red: the extra raise is dropped
    7'b1111000,  // green edit: blink, raise, commit, on to yellow
    7'b0110000,  // leave yellow: the raise is dropped, back to running
    7'b1111111,  // all inputs while running: lights load, red raised to ten and committed in red edit
    7'b0000000,  // red edit: ticks and expiries are ignored
    7'b0000100,
    7'b0000111,
    7'b0000100,
    7'b0000100,
    7'b1111111,  // every input in red edit: raise, commit, on to green
    7'b0010000,
    7'b0010000,
    7'b0010000   // back to running; both lights reload as red edit is entered again
  };

  two_way_traffic_light_controller_top i_dut (.*);

  two_way_traffic_light_controller_checker i_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("two_way_traffic_light_controller_top test failed");
    $finish;
  end

  // Result side: random stall per result, one long hold-off on request
  initial begin
    int n;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = rx_quiet ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one step after a random gap and hold it until taken
  task automatic send_step(input poll_t p);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    timer_a_expired <= p.expired_a;
    timer_b_expired <= p.expired_b;
    second_tick <= p.tick;
    blink_tick <= p.blink;
    mode_press <= p.mode;
    increment_press <= p.increment;
    commit_press <= p.commit;
    do @(posedge clk); while (in_stall);
    // track the mode the block should be in now
    case (sent_mode)
      MODE_START:       sent_mode = MODE_RUN;
      MODE_RUN:         if (p.mode) sent_mode = MODE_EDIT_RED;
      MODE_EDIT_RED:    if (p.mode) sent_mode = MODE_EDIT_GREEN;
      MODE_EDIT_GREEN:  if (p.mode) sent_mode = MODE_EDIT_YELLOW;
      default:          if (p.mode) sent_mode = MODE_RUN;
    endcase
  endtask

  // Wait until the checker has nothing outstanding
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    poll_t step;
    mode_t prev_mode;
    int    exp_pct;
    int    tick_pct;
    int    inc_burst;
    exp_pct = 25;
    tick_pct = 50;
    inc_burst = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) send_step(directed_steps[i]);
    wait_drained();

    for (int n = 0; n < RANDOM_STEPS; n++) begin
      // new traffic profile every hundred steps
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       exp_pct = 5;
          1:       exp_pct = 25;
          default: exp_pct = 60;
        endcase
        tick_pct = $urandom_range(30, 80);
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == 400) rx_hold_req = 1'b1;
      if (n == 800) wait_drained();

      if ($urandom_range(0, 19) == 0) begin
        step = poll_t'(7'($urandom_range(0, 127)));
      end else begin
        step.expired_a = ($urandom_range(0, 99) < exp_pct);
        step.expired_b = ($urandom_range(0, 99) < exp_pct);
        step.tick = ($urandom_range(0, 99) < tick_pct);
        if (sent_mode == MODE_RUN) begin
          step.mode = ($urandom_range(0, 99) < 4);
          step.blink = 1'($urandom_range(0, 1));
          step.increment = 1'($urandom_range(0, 1));
          step.commit = 1'($urandom_range(0, 1));
        end else begin
          step.mode = ($urandom_range(0, 99) < 10);
          step.blink = ($urandom_range(0, 99) < 50);
          step.increment = ($urandom_range(0, 99) < 60);
          step.commit = ($urandom_range(0, 99) < 25);
        end
      end
      // long raise runs reach the wrap past the largest duration
      if (inc_burst > 0) begin
        step.increment = 1'b1;
        step.mode = 1'b0;
        inc_burst--;
      end
      prev_mode = sent_mode;
      send_step(step);
      if (sent_mode != prev_mode && sent_mode >= MODE_EDIT_RED &&
          $urandom_range(0, 2) == 0)
        inc_burst = $urandom_range(90, 130);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("two_way_traffic_light_controller_top test passed");
    end else begin
      $display("two_way_traffic_light_controller_top test failed");
    end
    $finish;
  end

endmodule

FILE: two_way_traffic_light_controller_top.f
design/twtlc_pkg.sv
design/two_way_traffic_light_controller_top.sv
tb/two_way_traffic_light_controller_checker.sv
tb/tb_two_way_traffic_light_controller_top.sv
